// ----- rtl/limit_order_book_macros.svh -----
// Assertion macros shared by the order book RTL.
// Needs a clock i_clk and an active-low reset i_rst_n in the using module.
`ifndef LIMIT_ORDER_BOOK_MACROS_SVH
`define LIMIT_ORDER_BOOK_MACROS_SVH

// Check that cons holds in the same cycle as ante
`define LOB_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Check that cons holds in the cycle after ante
`define LOB_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ----- rtl/lob_pkg.sv -----
// Shared types and constants of the limit order book.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none
package lob_pkg;

    localparam int ORDER_SLOTS_DEF  = 4096;
    localparam int PRICE_LEVELS_DEF = 1024;
    localparam int SLOT_FW   = 12;
    localparam int PRICE_W   = 32;
    localparam int QTY_W     = 32;
    localparam int LOTS_W    = 48;
    localparam int SLOT_MAXW = 16;
    localparam int LVL_MAXW  = 14;
    localparam int IN_DATA_W  = 80;
    localparam int OUT_DATA_W = 104;

    typedef enum logic [1:0] {
        OP_ADD    = 2'd0,
        OP_CANCEL = 2'd1,
        OP_EXEC   = 2'd2,
        OP_NOP    = 2'd3
    } t_op;

    typedef enum logic [1:0] {
        ST_OK      = 2'd0,
        ST_UNKNOWN = 2'd1,
        ST_LIVE    = 2'd2,
        ST_WINDOW  = 2'd3
    } t_status;

    // Classified item passed from front to back
    typedef struct packed {
        t_op                   op;
        logic                  slot_ok;
        logic                  win_ok;
        logic                  side;
        logic [SLOT_MAXW-1:0]  slot;
        logic [LVL_MAXW-1:0]   level;
        logic [QTY_W-1:0]      qty;
    } t_cmd;

    // One order table entry
    typedef struct packed {
        logic                live;
        logic                side;
        logic [LVL_MAXW-1:0] level;
        logic [QTY_W-1:0]    lots;
    } t_ord;

    // Queue status seen by the back end
    typedef struct packed {
        logic valid;
        t_cmd cmd;
    } t_q_head;

endpackage
`default_nettype wire

// ----- rtl/limit_order_book.sv -----
// Limit order book top level: config register, front end and back end.
// Uses lob_pkg, lob_front and lob_back.
//
// Usage:
// - Input items arrive on the s_axis group: tuser holds op, tdata holds the
//   order fields. An item is taken when tvalid and tready are both high.
// - Results leave on the m_axis group, one per item, in input order:
//   tuser holds the status, tdata the best prices, flags and remaining lots.
// - price_base is written through the cfg channel; the user must do so only
//   while idle, as the block itself does not enforce it.
// - The back end handles one item at a time, from S_IDLE through the order
//   table read (S_ORD), level read and write (S_LVL, skipped if no level
//   changes) and two search steps (S_SRCH1, S_SRCH2) to the result register;
//   the order table and level memories allow one access each per cycle.
// - A two-entry queue sits between the front and back ends, and the result
//   register lets one more item finish while the receiver stalls; beyond that
//   the block lowers s_axis tready until the result is taken.
// - After reset a clearing pass zeroes the order and level tables; no item is
//   taken meanwhile.
`timescale 1ns / 1ps
`default_nettype none
module limit_order_book #(
    parameter int ORDER_SLOTS  = lob_pkg::ORDER_SLOTS_DEF,
    parameter int PRICE_LEVELS = lob_pkg::PRICE_LEVELS_DEF
) (
    input  wire logic                           i_clk,
    input  wire logic                           i_rst_n,
    input  wire logic                           i_cfg_valid,
    output logic                                o_cfg_ready,
    input  wire logic [lob_pkg::PRICE_W-1:0]    i_cfg_data,     // price_base
    input  wire logic                           i_s_axis_tvalid,
    output logic                                o_s_axis_tready,
    // order_slot[11:0], side[12], price[44:13], quantity[76:45], zero pad
    input  wire logic [lob_pkg::IN_DATA_W-1:0]  i_s_axis_tdata,
    input  wire logic [1:0]                     i_s_axis_tuser, // op
    output logic                                o_m_axis_tvalid,
    input  wire logic                           i_m_axis_tready,
    // best_bid_price[31:0], bid_present[32], best_ask_price[64:33],
    // ask_present[65], order_remaining[97:66], zero pad
    output logic [lob_pkg::OUT_DATA_W-1:0]      o_m_axis_tdata,
    output logic [1:0]                          o_m_axis_tuser  // status
);
    logic [lob_pkg::PRICE_W-1:0] r_price_base;
    lob_pkg::t_q_head            head;
    logic                        pop;
    logic                        back_ready;

    assign o_cfg_ready = 1'b1;

    // Hold the ladder base price
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_price_base <= '0;
        end else if (i_cfg_valid) begin
            r_price_base <= i_cfg_data;
        end
    end

    lob_front #(.ORDER_SLOTS(ORDER_SLOTS), .PRICE_LEVELS(PRICE_LEVELS)) u_front (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_enable       (back_ready),
        .i_price_base   (r_price_base),
        .i_s_axis_tvalid(i_s_axis_tvalid),
        .o_s_axis_tready(o_s_axis_tready),
        .i_s_axis_tdata (i_s_axis_tdata),
        .i_s_axis_tuser (i_s_axis_tuser),
        .i_pop          (pop),
        .o_head         (head)
    );

    lob_back #(.ORDER_SLOTS(ORDER_SLOTS), .PRICE_LEVELS(PRICE_LEVELS)) u_back (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_price_base   (r_price_base),
        .i_head         (head),
        .o_pop          (pop),
        .o_ready        (back_ready),
        .o_m_axis_tvalid(o_m_axis_tvalid),
        .i_m_axis_tready(i_m_axis_tready),
        .o_m_axis_tdata (o_m_axis_tdata),
        .o_m_axis_tuser (o_m_axis_tuser)
    );
endmodule
`default_nettype wire

// ----- rtl/lob_ram.sv -----
// Generic single-port-write, registered-read RAM.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none
module lob_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic      [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];

    // Write port and registered read port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end
endmodule
`default_nettype wire

// ----- rtl/lob_queue.sv -----
// Two-entry queue between the front and back ends.
// Uses lob_pkg for the item type.
`timescale 1ns / 1ps
`default_nettype none
module lob_queue (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_push,
    input  wire lob_pkg::t_cmd i_data,
    output logic             o_full,
    input  wire logic        i_pop,
    output lob_pkg::t_q_head o_head
);
    lob_pkg::t_cmd r_mem [2];
    logic          r_wp;
    logic          r_rp;
    logic [1:0]    r_cnt;

    // Advance pointers and count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= 1'b0;
            r_rp  <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            if (i_push) begin
                r_wp <= ~r_wp;
            end
            if (i_pop) begin
                r_rp <= ~r_rp;
            end
            r_cnt <= r_cnt + 2'(i_push) - 2'(i_pop);
        end
    end

    // Hold item payload
    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wp] <= i_data;
        end
    end

    assign o_full       = (r_cnt == 2'd2);
    assign o_head.valid = (r_cnt != 2'd0);
    assign o_head.cmd   = r_mem[r_rp];
endmodule
`default_nettype wire

// ----- rtl/lob_front.sv -----
// Front end: accepts input items, checks slot range and price window, queues them.
// Uses lob_pkg and lob_queue.
`timescale 1ns / 1ps
`default_nettype none
module lob_front #(
    parameter int ORDER_SLOTS  = lob_pkg::ORDER_SLOTS_DEF,
    parameter int PRICE_LEVELS = lob_pkg::PRICE_LEVELS_DEF
) (
    input  wire logic                         i_clk,
    input  wire logic                         i_rst_n,
    input  wire logic                         i_enable,
    input  wire logic [lob_pkg::PRICE_W-1:0]  i_price_base,
    input  wire logic                         i_s_axis_tvalid,
    output logic                              o_s_axis_tready,
    input  wire logic [lob_pkg::IN_DATA_W-1:0] i_s_axis_tdata,
    input  wire logic [1:0]                   i_s_axis_tuser,
    input  wire logic                         i_pop,
    output lob_pkg::t_q_head                  o_head
);
    logic                         full;
    logic                         push;
    logic [lob_pkg::SLOT_FW-1:0]  slot;
    logic [lob_pkg::PRICE_W-1:0]  price;
    logic [lob_pkg::PRICE_W:0]    diff;
    logic [lob_pkg::SLOT_MAXW:0]  slot_ext;
    lob_pkg::t_cmd                cmd;

    assign o_s_axis_tready = i_enable && !full;
    assign push            = i_s_axis_tvalid && o_s_axis_tready;

    // Classify the item
    always_comb begin
        slot     = i_s_axis_tdata[11:0];
        price    = i_s_axis_tdata[44:13];
        slot_ext = (lob_pkg::SLOT_MAXW+1)'(slot);
        diff     = {1'b0, price} - {1'b0, i_price_base};
        cmd.op      = lob_pkg::t_op'(i_s_axis_tuser);
        cmd.slot_ok = slot_ext < (lob_pkg::SLOT_MAXW+1)'(ORDER_SLOTS);
        cmd.win_ok  = !diff[lob_pkg::PRICE_W] &&
                      (diff[lob_pkg::PRICE_W-1:0] < lob_pkg::PRICE_W'(PRICE_LEVELS));
        cmd.side    = i_s_axis_tdata[12];
        cmd.slot    = lob_pkg::SLOT_MAXW'(slot);
        cmd.level   = diff[lob_pkg::LVL_MAXW-1:0];
        cmd.qty     = i_s_axis_tdata[76:45];
    end

    lob_queue u_queue (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_push (push),
        .i_data (cmd),
        .o_full (full),
        .i_pop  (i_pop),
        .o_head (o_head)
    );
endmodule
`default_nettype wire

// ----- rtl/lob_back.sv -----
// Back end: order table and level ladders, best price search, result register.
// Uses lob_pkg, lob_ram and the assertion macros.
`timescale 1ns / 1ps
`default_nettype none
`include "limit_order_book_macros.svh"
module lob_back #(
    parameter int ORDER_SLOTS  = lob_pkg::ORDER_SLOTS_DEF,
    parameter int PRICE_LEVELS = lob_pkg::PRICE_LEVELS_DEF
) (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire logic [lob_pkg::PRICE_W-1:0]   i_price_base,
    input  wire lob_pkg::t_q_head              i_head,
    output logic                               o_pop,
    output logic                               o_ready,
    output logic                               o_m_axis_tvalid,
    input  wire logic                          i_m_axis_tready,
    output logic [lob_pkg::OUT_DATA_W-1:0]     o_m_axis_tdata,
    output logic [1:0]                         o_m_axis_tuser
);
    localparam int SLOT_W = $clog2(ORDER_SLOTS);
    localparam int LVL_W  = $clog2(PRICE_LEVELS);
    localparam int LA_W   = LVL_W + 1;
    localparam int GW     = (PRICE_LEVELS < 32) ? PRICE_LEVELS : 32;
    localparam int NG     = PRICE_LEVELS / GW;
    localparam int GB_W   = $clog2(GW);
    localparam int GI_W   = (NG > 1) ? $clog2(NG) : 1;
    localparam int CLR_N  = (ORDER_SLOTS > 2*PRICE_LEVELS) ? ORDER_SLOTS : 2*PRICE_LEVELS;
    localparam int CLR_W  = $clog2(CLR_N) + 1;
    localparam int ORD_W  = $bits(lob_pkg::t_ord);
    localparam logic [lob_pkg::LOTS_W-1:0] LOTS_MAX = '1;

    typedef enum logic [2:0] {
        S_CLEAR, S_IDLE, S_ORD, S_LVL, S_SRCH1, S_SRCH2
    } t_state;

    t_state                        r_state;
    logic [CLR_W-1:0]              r_clr;
    lob_pkg::t_cmd                 r_cmd;
    logic                          r_add;
    logic                          r_side;
    logic [LVL_W-1:0]              r_lvl;
    logic [lob_pkg::QTY_W-1:0]     r_amt;
    lob_pkg::t_status              r_status;
    logic [lob_pkg::QTY_W-1:0]     r_rem;
    logic [GI_W-1:0]               r_bgrp;
    logic [GI_W-1:0]               r_agrp;
    logic                          r_bany;
    logic                          r_aany;
    logic [GW-1:0]                 r_bid_used [NG];
    logic [GW-1:0]                 r_ask_used [NG];
    logic                          r_out_valid;
    lob_pkg::t_status              r_out_status;
    logic [lob_pkg::PRICE_W-1:0]   r_out_bid;
    logic                          r_out_bidf;
    logic [lob_pkg::PRICE_W-1:0]   r_out_ask;
    logic                          r_out_askf;
    logic [lob_pkg::QTY_W-1:0]     r_out_rem;

    logic                          ord_we;
    logic [SLOT_W-1:0]             ord_waddr;
    logic [SLOT_W-1:0]             ord_raddr;
    lob_pkg::t_ord                 ord_wdata;
    logic [ORD_W-1:0]              ord_rdata;
    lob_pkg::t_ord                 ord_q;
    logic                          lvl_we;
    logic [LA_W-1:0]               lvl_waddr;
    logic [LA_W-1:0]               lvl_raddr;
    logic [lob_pkg::LOTS_W-1:0]    lvl_wdata;
    logic [lob_pkg::LOTS_W-1:0]    lvl_q;

    lob_pkg::t_status              d_status;
    logic [lob_pkg::QTY_W-1:0]     d_rem;
    logic                          d_go;
    logic                          d_add;
    logic                          d_side;
    logic [LVL_W-1:0]              d_lvl;
    logic [lob_pkg::QTY_W-1:0]     d_amt;
    logic                          d_ord_we;
    lob_pkg::t_ord                 d_ord;
    logic [lob_pkg::QTY_W-1:0]     fill;
    logic [lob_pkg::LOTS_W:0]      lvl_sum;
    logic [lob_pkg::LOTS_W-1:0]    lvl_new;
    logic [NG-1:0]                 bsum;
    logic [NG-1:0]                 asum;
    logic [GI_W-1:0]               bgrp;
    logic [GI_W-1:0]               agrp;
    logic [GW-1:0]                 bword;
    logic [GW-1:0]                 aword;
    logic [GB_W-1:0]               bbit;
    logic [GB_W-1:0]               abit;
    logic [GI_W-1:0]               u_grp;
    logic [GB_W-1:0]               u_bit;
    logic                          clear_done;
    logic                          out_load;

    assign ord_q      = lob_pkg::t_ord'(ord_rdata);
    assign clear_done = (r_clr == CLR_W'(CLR_N - 1));
    assign o_ready    = (r_state != S_CLEAR);
    assign o_pop      = (r_state == S_IDLE) && i_head.valid;
    assign out_load   = (r_state == S_SRCH2) && (!r_out_valid || i_m_axis_tready);

    // Decide the outcome once the order entry is read
    always_comb begin
        fill     = (r_cmd.qty < ord_q.lots) ? r_cmd.qty : ord_q.lots;
        d_status = lob_pkg::ST_OK;
        d_rem    = '0;
        d_go     = 1'b0;
        d_add    = 1'b0;
        d_side   = ord_q.side;
        d_lvl    = ord_q.level[LVL_W-1:0];
        d_amt    = ord_q.lots;
        d_ord_we = 1'b0;
        d_ord    = ord_q;
        if (r_cmd.op == lob_pkg::OP_NOP) begin
            d_status = lob_pkg::ST_OK;
        end else if (!r_cmd.slot_ok) begin
            d_status = lob_pkg::ST_UNKNOWN;
        end else if (r_cmd.op == lob_pkg::OP_ADD) begin
            if (ord_q.live) begin
                d_status = lob_pkg::ST_LIVE;
                d_rem    = ord_q.lots;
            end else if (!r_cmd.win_ok) begin
                d_status = lob_pkg::ST_WINDOW;
            end else begin
                d_go       = 1'b1;
                d_add      = 1'b1;
                d_side     = r_cmd.side;
                d_lvl      = r_cmd.level[LVL_W-1:0];
                d_amt      = r_cmd.qty;
                d_rem      = r_cmd.qty;
                d_ord_we   = 1'b1;
                d_ord.live = 1'b1;
                d_ord.side = r_cmd.side;
                d_ord.level = r_cmd.level;
                d_ord.lots = r_cmd.qty;
            end
        end else if (!ord_q.live) begin
            d_status = lob_pkg::ST_UNKNOWN;
        end else if (r_cmd.op == lob_pkg::OP_CANCEL) begin
            d_go       = 1'b1;
            d_ord_we   = 1'b1;
            d_ord.live = 1'b0;
            d_ord.lots = '0;
        end else begin
            d_go       = 1'b1;
            d_amt      = fill;
            d_rem      = ord_q.lots - fill;
            d_ord_we   = 1'b1;
            d_ord.lots = ord_q.lots - fill;
            d_ord.live = (ord_q.lots != fill);
        end
    end

    // Memory ports: clearing pass, then order and level updates
    always_comb begin
        ord_raddr = i_head.cmd.slot[SLOT_W-1:0];
        lvl_raddr = {d_side, d_lvl};
        if (r_state == S_CLEAR) begin
            ord_we    = r_clr < CLR_W'(ORDER_SLOTS);
            ord_waddr = r_clr[SLOT_W-1:0];
            ord_wdata = '0;
            lvl_we    = r_clr < CLR_W'(2*PRICE_LEVELS);
            lvl_waddr = r_clr[LA_W-1:0];
            lvl_wdata = '0;
        end else begin
            ord_we    = (r_state == S_ORD) && d_ord_we;
            ord_waddr = r_cmd.slot[SLOT_W-1:0];
            ord_wdata = d_ord;
            lvl_we    = (r_state == S_LVL);
            lvl_waddr = {r_side, r_lvl};
            lvl_wdata = lvl_new;
        end
    end

    // Saturating level arithmetic
    always_comb begin
        lvl_sum = {1'b0, lvl_q} + (lob_pkg::LOTS_W+1)'(r_amt);
        if (r_add) begin
            lvl_new = lvl_sum[lob_pkg::LOTS_W] ? LOTS_MAX : lvl_sum[lob_pkg::LOTS_W-1:0];
        end else begin
            lvl_new = (lvl_q > lob_pkg::LOTS_W'(r_amt)) ?
                      lvl_q - lob_pkg::LOTS_W'(r_amt) : '0;
        end
        u_grp = GI_W'(r_lvl >> GB_W);
        u_bit = GB_W'(r_lvl);
    end

    // Group summary and first-level search
    always_comb begin
        bgrp = '0;
        agrp = '0;
        for (int g = 0; g < NG; g++) begin
            bsum[g] = |r_bid_used[g];
            asum[g] = |r_ask_used[g];
        end
        for (int g = 0; g < NG; g++) begin
            if (bsum[g]) begin
                bgrp = GI_W'(g);
            end
        end
        for (int g = NG - 1; g >= 0; g--) begin
            if (asum[g]) begin
                agrp = GI_W'(g);
            end
        end
    end

    // Second-level search inside the chosen group
    always_comb begin
        bword = r_bid_used[r_bgrp];
        aword = r_ask_used[r_agrp];
        bbit  = '0;
        abit  = '0;
        for (int b = 0; b < GW; b++) begin
            if (bword[b]) begin
                bbit = GB_W'(b);
            end
        end
        for (int b = GW - 1; b >= 0; b--) begin
            if (aword[b]) begin
                abit = GB_W'(b);
            end
        end
    end

    // Sequencer and result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_CLEAR;
            r_clr       <= '0;
            r_out_valid <= 1'b0;
            for (int g = 0; g < NG; g++) begin
                r_bid_used[g] <= '0;
                r_ask_used[g] <= '0;
            end
        end else begin
            // Load a finished result, drop one that the receiver took
            if (out_load) begin
                r_out_valid <= 1'b1;
            end else if (i_m_axis_tready) begin
                r_out_valid <= 1'b0;
            end
            case (r_state)
                S_CLEAR: begin
                    r_clr <= r_clr + CLR_W'(1);
                    if (clear_done) begin
                        r_state <= S_IDLE;
                    end
                end
                S_IDLE: begin
                    if (i_head.valid) begin
                        r_cmd   <= i_head.cmd;
                        r_state <= S_ORD;
                    end
                end
                S_ORD: begin
                    r_status <= d_status;
                    r_rem    <= d_rem;
                    r_add    <= d_add;
                    r_side   <= d_side;
                    r_lvl    <= d_lvl;
                    r_amt    <= d_amt;
                    r_state  <= d_go ? S_LVL : S_SRCH1;
                end
                S_LVL: begin
                    if (r_side) begin
                        r_ask_used[u_grp][u_bit] <= (lvl_new != '0);
                    end else begin
                        r_bid_used[u_grp][u_bit] <= (lvl_new != '0);
                    end
                    r_state <= S_SRCH1;
                end
                S_SRCH1: begin
                    r_bgrp  <= bgrp;
                    r_agrp  <= agrp;
                    r_bany  <= |bsum;
                    r_aany  <= |asum;
                    r_state <= S_SRCH2;
                end
                S_SRCH2: begin
                    if (out_load) begin
                        r_out_status <= r_status;
                        r_out_rem    <= r_rem;
                        r_out_bidf   <= r_bany;
                        r_out_askf   <= r_aany;
                        r_out_bid    <= r_bany ? i_price_base +
                                        lob_pkg::PRICE_W'({r_bgrp, bbit}) : '0;
                        r_out_ask    <= r_aany ? i_price_base +
                                        lob_pkg::PRICE_W'({r_agrp, abit}) : '0;
                        r_state      <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    assign o_m_axis_tvalid = r_out_valid;
    assign o_m_axis_tuser  = r_out_status;
    assign o_m_axis_tdata  = {6'd0, r_out_rem, r_out_askf, r_out_ask, r_out_bidf, r_out_bid};

    lob_ram #(.WIDTH(ORD_W), .DEPTH(ORDER_SLOTS)) u_ord_ram (
        .i_clk  (i_clk),
        .i_we   (ord_we),
        .i_waddr(ord_waddr),
        .i_wdata(ord_wdata),
        .i_raddr(ord_raddr),
        .o_rdata(ord_rdata)
    );

    lob_ram #(.WIDTH(lob_pkg::LOTS_W), .DEPTH(2*PRICE_LEVELS)) u_lvl_ram (
        .i_clk  (i_clk),
        .i_we   (lvl_we),
        .i_waddr(lvl_waddr),
        .i_wdata(lvl_wdata),
        .i_raddr(lvl_raddr),
        .o_rdata(lvl_q)
    );

    `LOB_ASSERT_NOW(a_no_pop_in_clear, r_state == S_CLEAR, !o_pop, "item taken during clear")
    `LOB_ASSERT_NOW(a_ask_word_set, (r_state == S_SRCH2) && r_aany, aword != '0,
        "ask summary without level")
    `LOB_ASSERT_NEXT(a_add_goes_level, (r_state == S_ORD) && d_add, r_state == S_LVL,
        "accepted add skipped level update")
endmodule
`default_nettype wire

// ----- tb/testbench.sv -----
// Self-checking testbench for limit_order_book: random-stall streams, a
// built-in order book predictor and a result checker. Depends on lob_pkg.
`timescale 1ns / 1ps
module testbench;

    localparam int SLOTS      = lob_pkg::ORDER_SLOTS_DEF;
    localparam int LEVELS     = lob_pkg::PRICE_LEVELS_DEF;
    localparam int STALL_MAX  = 19;
    localparam int IDLE_LIMIT = 30000;
    localparam logic [lob_pkg::LOTS_W-1:0] LOTS_SAT = '1;

    typedef struct {
        lob_pkg::t_status status;
        logic [31:0]      bid_price;
        logic             bid_flag;
        logic [31:0]      ask_price;
        logic             ask_flag;
        logic [31:0]      remaining;
    } t_quote;

    logic                           i_clk;
    logic                           i_rst_n;
    logic                           cfg_valid;
    logic [lob_pkg::PRICE_W-1:0]    cfg_data;
    logic                           s_valid;
    logic [lob_pkg::IN_DATA_W-1:0]  s_data;
    logic [1:0]                     s_user;
    logic                           m_ready;
    logic                           cfg_ready;
    logic                           s_ready;
    logic                           m_valid;
    logic [lob_pkg::OUT_DATA_W-1:0] m_data;
    logic [1:0]                     m_user;

    // Predictor state: order table, level ladders and the window base
    logic                        book_live  [SLOTS];
    logic                        book_side  [SLOTS];
    int                          book_level [SLOTS];
    logic [31:0]                 book_lots  [SLOTS];
    logic [lob_pkg::LOTS_W-1:0]  bid_lots   [LEVELS];
    logic [lob_pkg::LOTS_W-1:0]  ask_lots   [LEVELS];
    logic [31:0]                 window_base;

    t_quote      quotes_due[$];
    int          fail_count;
    int          items_sent;
    int          quotes_seen;
    int          idle_cycles = 0;
    bit          steady;

    limit_order_book DUT (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cfg_valid    (cfg_valid),
        .o_cfg_ready    (cfg_ready),
        .i_cfg_data     (cfg_data),
        .i_s_axis_tvalid(s_valid),
        .o_s_axis_tready(s_ready),
        .i_s_axis_tdata (s_data),
        .i_s_axis_tuser (s_user),
        .o_m_axis_tvalid(m_valid),
        .i_m_axis_tready(m_ready),
        .o_m_axis_tdata (m_data),
        .o_m_axis_tuser (m_user)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // Remove lots from a level, floor at zero
    function automatic void level_take(logic sd, int lv, logic [lob_pkg::LOTS_W-1:0] amt);
        if (sd) ask_lots[lv] = (ask_lots[lv] > amt) ? ask_lots[lv] - amt : '0;
        else    bid_lots[lv] = (bid_lots[lv] > amt) ? bid_lots[lv] - amt : '0;
    endfunction

    // Apply one order item to the book and return the expected quote
    function automatic t_quote book_apply(lob_pkg::t_op op, int slot, logic sd,
                                          logic [31:0] price, logic [31:0] qty);
        t_quote q;
        logic [31:0] fill;
        longint unsigned offs;
        int lv;
        q = '{lob_pkg::ST_OK, 32'd0, 1'b0, 32'd0, 1'b0, 32'd0};
        offs = longint'(price) - longint'(window_base);
        case (op)
            lob_pkg::OP_ADD: begin
                if (book_live[slot]) begin
                    q.status = lob_pkg::ST_LIVE;
                    q.remaining = book_lots[slot];
                end else if (price < window_base || offs >= LEVELS) begin
                    q.status = lob_pkg::ST_WINDOW;
                end else begin
                    lv = int'(offs);
                    book_live[slot] = 1'b1;
                    book_side[slot] = sd;
                    book_level[slot] = lv;
                    book_lots[slot] = qty;
                    if (sd) ask_lots[lv] = (LOTS_SAT - ask_lots[lv] < qty) ?
                                           LOTS_SAT : ask_lots[lv] + qty;
                    else    bid_lots[lv] = (LOTS_SAT - bid_lots[lv] < qty) ?
                                           LOTS_SAT : bid_lots[lv] + qty;
                    q.remaining = qty;
                end
            end
            lob_pkg::OP_CANCEL, lob_pkg::OP_EXEC: begin
                if (!book_live[slot]) begin
                    q.status = lob_pkg::ST_UNKNOWN;
                end else if (op == lob_pkg::OP_CANCEL) begin
                    level_take(book_side[slot], book_level[slot], book_lots[slot]);
                    book_live[slot] = 1'b0;
                    book_lots[slot] = '0;
                end else begin
                    fill = (qty < book_lots[slot]) ? qty : book_lots[slot];
                    book_lots[slot] -= fill;
                    level_take(book_side[slot], book_level[slot], fill);
                    if (book_lots[slot] == 0) book_live[slot] = 1'b0;
                    q.remaining = book_lots[slot];
                end
            end
            default: ;
        endcase
        // Search best bid from the top, best ask from the bottom
        for (int i = LEVELS - 1; i >= 0; i--) begin
            if (bid_lots[i] != 0) begin
                q.bid_price = window_base + 32'(i);
                q.bid_flag = 1'b1;
                break;
            end
        end
        for (int i = 0; i < LEVELS; i++) begin
            if (ask_lots[i] != 0) begin
                q.ask_price = window_base + 32'(i);
                q.ask_flag = 1'b1;
                break;
            end
        end
        return q;
    endfunction

    // Send one order item after a random gap and predict its quote
    task automatic send_order(lob_pkg::t_op op, int slot, logic sd,
                              logic [31:0] price, logic [31:0] qty);
        int gap;
        gap = steady ? 0 : $urandom_range(0, STALL_MAX);
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        s_valid <= 1'b1;
        s_user  <= op;
        s_data  <= {3'b000, qty, price, sd, slot[11:0]};
        do @(posedge i_clk); while (!s_ready);
        quotes_due.push_back(book_apply(op, slot, sd, price, qty));
        items_sent++;
    endtask

    // Hold the sender until every outstanding quote has arrived
    task automatic drain_quotes();
        s_valid <= 1'b0;
        while (quotes_due.size() != 0) @(posedge i_clk);
        repeat (10) @(posedge i_clk);
    endtask

    // Write price_base while the block is idle
    task automatic set_base(logic [31:0] base);
        drain_quotes();
        cfg_valid <= 1'b1;
        cfg_data  <= base;
        do @(posedge i_clk); while (!cfg_ready);
        cfg_valid <= 1'b0;
        window_base = base;
    endtask

    // Pick a slot, preferring live ones from a small pool
    function automatic int pick_live();
        int s;
        for (int k = 0; k < 8; k++) begin
            s = $urandom_range(0, 63);
            if (book_live[s]) return s;
        end
        return s;
    endfunction

    task automatic test_directed();
        set_base(32'd1000);
        send_order(lob_pkg::OP_ADD, 0, 1'b0, 32'd1000, 32'd5);           // lowest level
        send_order(lob_pkg::OP_ADD, 4095, 1'b1, 32'd2023, 32'hFFFF_FFFF); // top, max lots
        send_order(lob_pkg::OP_ADD, 0, 1'b1, 32'd1200, 32'd9);           // slot already live
        send_order(lob_pkg::OP_ADD, 1, 1'b0, 32'd999, 32'd1);            // below window
        send_order(lob_pkg::OP_ADD, 1, 1'b1, 32'd2024, 32'd1);           // above window
        send_order(lob_pkg::OP_ADD, 2, 1'b0, 32'hFFFF_FFFF, 32'd1);
        send_order(lob_pkg::OP_ADD, 2, 1'b0, 32'd0, 32'd1);
        send_order(lob_pkg::OP_ADD, 3, 1'b1, 32'd1500, 32'd0);           // zero lots
        send_order(lob_pkg::OP_ADD, 4, 1'b0, 32'd1500, 32'd7);
        send_order(lob_pkg::OP_EXEC, 4, 1'b0, 32'd0, 32'd3);             // partial fill
        send_order(lob_pkg::OP_EXEC, 4, 1'b1, 32'hFFFF_FFFF, 32'hFFFF_FFFF); // overfill
        send_order(lob_pkg::OP_EXEC, 4, 1'b0, 32'd0, 32'd1);             // now unknown
        send_order(lob_pkg::OP_CANCEL, 0, 1'b0, 32'd0, 32'd0);
        send_order(lob_pkg::OP_CANCEL, 0, 1'b0, 32'd0, 32'd0);           // unknown cancel
        send_order(lob_pkg::OP_NOP, 5, 1'b1, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
        send_order(lob_pkg::OP_EXEC, 3, 1'b0, 32'd0, 32'd0);             // zero-lot order freed
        send_order(lob_pkg::OP_ADD, 6, 1'b1, 32'd1010, 32'd4);
        send_order(lob_pkg::OP_CANCEL, 4095, 1'b0, 32'd0, 32'd0);
    endtask

    // Mostly well-formed add/cancel/fill traffic, with some noise
    task automatic test_random(logic [31:0] base, int count);
        int pick, slot;
        logic [31:0] price, qty;
        lob_pkg::t_op op;
        set_base(base);
        for (int n = 0; n < count; n++) begin
            if (n % 100 == 0) steady = ($urandom_range(0, 3) == 0);
            if (n == count / 2) drain_quotes();
            pick  = $urandom_range(0, 99);
            slot  = ($urandom_range(0, 9) == 0) ? $urandom_range(0, SLOTS - 1)
                                                : $urandom_range(0, 63);
            price = window_base + $urandom_range(0, LEVELS - 1);
            qty   = ($urandom_range(0, 2) == 0) ? $urandom() : $urandom_range(0, 500);
            if (pick < 45) begin
                op = lob_pkg::OP_ADD;
            end else if (pick < 70) begin
                op = lob_pkg::OP_CANCEL;
                slot = pick_live();
            end else if (pick < 90) begin
                op = lob_pkg::OP_EXEC;
                slot = pick_live();
                if (book_live[slot] && $urandom_range(0, 1))
                    qty = $urandom_range(1, book_lots[slot]);
            end else begin
                op = lob_pkg::t_op'($urandom_range(0, 3));
                price = $urandom();
            end
            send_order(op, slot, $urandom_range(0, 1), price, qty);
        end
        steady = 1'b0;
    endtask

    task automatic check_field(string name, logic [31:0] want, logic [31:0] got);
        if (want !== got) begin
            $error("%s mismatch: expected %0h, got %0h", name, want, got);
            fail_count++;
        end
    endtask

    // Take quotes with random stalls and compare with the oldest prediction
    initial begin
        t_quote want;
        int stall;
        m_ready <= 1'b0;
        @(posedge i_rst_n);
        forever begin
            stall = steady ? 0 : $urandom_range(0, STALL_MAX);
            if (stall > 0) begin
                m_ready <= 1'b0;
                repeat (stall) @(posedge i_clk);
            end
            m_ready <= 1'b1;
            do @(posedge i_clk); while (!m_valid);
            quotes_seen++;
            if (quotes_due.size() == 0) begin
                $error("quote with no item outstanding");
                fail_count++;
            end else begin
                want = quotes_due.pop_front();
                check_field("status", want.status, m_user);
                check_field("best_bid_price", want.bid_price, m_data[31:0]);
                check_field("bid_present", want.bid_flag, m_data[32]);
                check_field("best_ask_price", want.ask_price, m_data[64:33]);
                check_field("ask_present", want.ask_flag, m_data[65]);
                check_field("order_remaining", want.remaining, m_data[97:66]);
            end
        end
    end

    // Watchdog: end the run when nothing moves for too long
    always @(posedge i_clk) begin
        if ((s_valid && s_ready) || (m_valid && m_ready) || (cfg_valid && cfg_ready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= IDLE_LIMIT) begin
            $display("TB_ERROR");
            $finish;
        end
    end

    initial begin
        i_rst_n     <= 1'b0;
        cfg_valid   <= 1'b0;
        cfg_data    <= '0;
        s_valid     <= 1'b0;
        s_data      <= '0;
        s_user      <= lob_pkg::OP_NOP;
        fail_count  = 0;
        items_sent  = 0;
        quotes_seen = 0;
        steady      = 1'b0;
        window_base = '0;
        for (int i = 0; i < SLOTS; i++) begin
            book_live[i] = 1'b0;
            book_lots[i] = '0;
        end
        for (int i = 0; i < LEVELS; i++) begin
            bid_lots[i] = '0;
            ask_lots[i] = '0;
        end
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_directed();
        test_random(32'd0, 500);
        test_random(32'hFFFF_FC00, 500);
        test_random(32'hFFFF_FFFF, 200);
        test_random($urandom(), 600);
        drain_quotes();

        $display("Sent %0d order items over five price bases, checked %0d quotes.",
                 items_sent, quotes_seen);
        $display("Covered adds, cancels, fills, overfills, window and live-slot rejects.");
        if (fail_count == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end

endmodule
